// ===== rtl/core/topo_pkg.sv =====
// ----------------------------------------------------------------------------
// topo_pkg
// shared types and codes of the topological order enumerator
// ----------------------------------------------------------------------------
package topo_pkg;

  // item indices are carried as four bits, so at most sixteen items take part
  localparam int IDX_W = 4;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_NEXT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FEAS,
    ST_SCAN,
    ST_BACK,
    ST_POP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT,
    ST_FIN_WAIT
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] wdata;
  } stack_req_t;

  typedef struct packed {
    logic             clr;
    logic             add;
    logic [IDX_W-1:0] earlier;
    logic [IDX_W-1:0] later;
  } pred_cmd_t;

endpackage

// ===== rtl/core/topo_stack.sv =====
// ----------------------------------------------------------------------------
// topo_stack
// stack of chosen items, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module topo_stack #(
  parameter int CAP = 16
) (
  input  logic                          clk,
  input  topo_pkg::stack_req_t          req,
  output logic [topo_pkg::IDX_W-1:0]    rdata
);

  localparam int CIW = $clog2(CAP);

  logic [CIW-1:0] mem [CAP];
  logic [CIW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr[CIW-1:0]] <= req.wdata[CIW-1:0];
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr[CIW-1:0]];
    end
  end

  assign rdata = topo_pkg::IDX_W'(rdata_r);

endmodule

// ===== rtl/core/topo_pred_table.sv =====
// ----------------------------------------------------------------------------
// topo_pred_table
// predecessor masks and the shared placeability test for one candidate
// ----------------------------------------------------------------------------
module topo_pred_table #(
  parameter int CAP = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  topo_pkg::pred_cmd_t         cmd,
  input  logic [$clog2(CAP)-1:0]      query_idx,
  input  logic [CAP-1:0]              placed,
  output logic                        placeable
);

  localparam int CIW = $clog2(CAP);

  logic [CAP-1:0] mask_r [CAP];
  logic [CAP-1:0] pm;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      mask_r <= '{default: '0};
    end else if (cmd.add && (cmd.earlier < CAP) && (cmd.later < CAP)) begin
      mask_r[cmd.later[CIW-1:0]][cmd.earlier[CIW-1:0]] <= 1'b1;
    end
  end

  // candidate is free and all of its predecessors are already placed
  assign pm        = mask_r[query_idx];
  assign placeable = !placed[query_idx] && ((placed & pm) == pm);

endmodule

// ===== rtl/core/topological_order_enumerator.sv =====
// clear and add items are applied as they are accepted; a next item runs a search
// the first next after a restart first runs a cycle check over the active items,
// then one candidate per cycle through the shared placeability test, a registered
// stack read and a pop per backtrack, and a stack read, load and hand-off per result
// one item at a time: in_stall is high until the last result of an item is taken
// synchronous active-low reset: masks cleared, item_count 16, enumeration restarted
// ----------------------------------------------------------------------------
// topological_order_enumerator
// resumable depth-first enumeration of all topological orderings
// ----------------------------------------------------------------------------
module topological_order_enumerator #(
  parameter int MAX_ITEMS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_item_count,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [3:0] in_earlier_index,
  input  logic [3:0] in_later_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_item_index,
  output logic       out_last_of_ordering,
  output logic       out_finished,
  output logic       out_none_found
);

  localparam int CAP = (MAX_ITEMS < 16) ? MAX_ITEMS : 16;
  localparam int CIW = $clog2(CAP);
  localparam int LW  = $clog2(CAP + 1);
  localparam int IW  = topo_pkg::IDX_W;

  topo_pkg::state_t     state_r, state_nxt;
  topo_pkg::stack_req_t stack_req;
  topo_pkg::pred_cmd_t  pred_cmd;

  logic [LW-1:0]  n_r, n_nxt, n_cfg;
  logic [CAP-1:0] placed_r, placed_nxt;
  logic [LW-1:0]  lvl_r, lvl_nxt;
  logic [LW-1:0]  cand_r, cand_nxt;
  logic [LW-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]  k_r, k_nxt;
  logic           prog_r, prog_nxt;
  logic           started_r, started_nxt;
  logic           done_r, done_nxt;
  logic           any_r, any_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [3:0]     out_item_r, out_item_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_fin_r, out_fin_nxt;
  logic           out_none_r, out_none_nxt;

  logic [IW-1:0]  stack_rdata;
  logic           placeable;
  logic           acc_in;
  logic           acc_next;
  logic [LW-1:0]  n_m1;
  logic           pass_end;
  logic [LW-1:0]  cnt_inc;
  logic           feas_full;
  logic           feas_prog;
  logic           cand_end;
  logic [CAP-1:0] cand_bit;
  logic [CIW-1:0] pop_idx;
  logic           give_fin;

  topo_pred_table #(.CAP(CAP)) u_pred (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pred_cmd),
    .query_idx (cand_r[CIW-1:0]),
    .placed    (placed_r),
    .placeable (placeable)
  );

  topo_stack #(.CAP(CAP)) u_stack (
    .clk   (clk),
    .req   (stack_req),
    .rdata (stack_rdata)
  );

  assign in_stall = (state_r != topo_pkg::ST_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign acc_next = acc_in && (in_func == topo_pkg::FUNC_NEXT);

  assign n_m1      = n_r - LW'(1);
  assign pass_end  = (cand_r == n_m1);
  assign cnt_inc   = cnt_r + LW'(placeable);
  assign feas_full = (cnt_inc == n_r);
  assign feas_prog = prog_r || placeable;
  assign cand_end  = (cand_r >= n_r);
  assign cand_bit  = CAP'(1) << cand_r[CIW-1:0];
  assign pop_idx   = stack_rdata[CIW-1:0];

  // item count as the search sees it: zero acts as one, large values clamp
  always_comb begin
    if (cfg_item_count == 5'd0) begin
      n_cfg = LW'(1);
    end else if (cfg_item_count > CAP) begin
      n_cfg = LW'(CAP);
    end else begin
      n_cfg = LW'(cfg_item_count);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      topo_pkg::ST_IDLE: begin
        if (acc_next) begin
          if (done_r) begin
            state_nxt = topo_pkg::ST_FIN_WAIT;
          end else if (!started_r) begin
            state_nxt = topo_pkg::ST_FEAS;
          end else begin
            state_nxt = topo_pkg::ST_BACK;
          end
        end
      end
      topo_pkg::ST_FEAS: begin
        if (pass_end) begin
          if (feas_full) begin
            state_nxt = topo_pkg::ST_SCAN;
          end else if (!feas_prog) begin
            state_nxt = topo_pkg::ST_FIN_WAIT;
          end
        end
      end
      topo_pkg::ST_SCAN: begin
        if (lvl_r == n_r) begin
          state_nxt = topo_pkg::ST_EMIT_RD;
        end else if (cand_end) begin
          state_nxt = topo_pkg::ST_BACK;
        end
      end
      topo_pkg::ST_BACK: begin
        if (lvl_r == '0) begin
          state_nxt = topo_pkg::ST_FIN_WAIT;
        end else begin
          state_nxt = topo_pkg::ST_POP;
        end
      end
      topo_pkg::ST_POP:     state_nxt = topo_pkg::ST_SCAN;
      topo_pkg::ST_EMIT_RD: state_nxt = topo_pkg::ST_EMIT_LD;
      topo_pkg::ST_EMIT_LD: state_nxt = topo_pkg::ST_EMIT_WAIT;
      topo_pkg::ST_EMIT_WAIT: begin
        if (!out_stall) begin
          state_nxt = out_last_r ? topo_pkg::ST_IDLE : topo_pkg::ST_EMIT_RD;
        end
      end
      topo_pkg::ST_FIN_WAIT: begin
        if (!out_stall) begin
          state_nxt = topo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = topo_pkg::ST_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    n_nxt         = n_r;
    placed_nxt    = placed_r;
    lvl_nxt       = lvl_r;
    cand_nxt      = cand_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    prog_nxt      = prog_r;
    started_nxt   = started_r;
    done_nxt      = done_r;
    any_nxt       = any_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    out_last_nxt  = out_last_r;
    out_fin_nxt   = out_fin_r;
    out_none_nxt  = out_none_r;
    stack_req     = '0;
    pred_cmd      = '0;
    give_fin      = 1'b0;

    unique case (state_r)
      topo_pkg::ST_IDLE: begin
        if (acc_in) begin
          case (in_func)
            topo_pkg::FUNC_CLEAR, topo_pkg::FUNC_ADD: begin
              pred_cmd.clr     = (in_func == topo_pkg::FUNC_CLEAR);
              pred_cmd.add     = (in_func == topo_pkg::FUNC_ADD);
              pred_cmd.earlier = in_earlier_index;
              pred_cmd.later   = in_later_index;
              placed_nxt       = '0;
              lvl_nxt          = '0;
              started_nxt      = 1'b0;
              done_nxt         = 1'b0;
              any_nxt          = 1'b0;
            end
            topo_pkg::FUNC_NEXT: begin
              if (done_r) begin
                give_fin = 1'b1;
              end else if (!started_r) begin
                started_nxt = 1'b1;
                placed_nxt  = '0;
                lvl_nxt     = '0;
                cand_nxt    = '0;
                cnt_nxt     = '0;
                prog_nxt    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      topo_pkg::ST_FEAS: begin
        // repeated passes placing whatever is placeable, until stuck or complete
        if (placeable) begin
          placed_nxt = placed_r | cand_bit;
        end
        cnt_nxt  = cnt_inc;
        prog_nxt = feas_prog;
        cand_nxt = cand_r + LW'(1);
        if (pass_end) begin
          cand_nxt = '0;
          prog_nxt = 1'b0;
          if (feas_full) begin
            placed_nxt = '0;
            lvl_nxt    = '0;
          end else if (!feas_prog) begin
            give_fin = 1'b1;
          end
        end
      end
      topo_pkg::ST_SCAN: begin
        if (lvl_r == n_r) begin
          any_nxt = 1'b1;
          k_nxt   = '0;
        end else if (!cand_end) begin
          if (placeable) begin
            stack_req.wr_en = 1'b1;
            stack_req.addr  = IW'(lvl_r);
            stack_req.wdata = IW'(cand_r);
            placed_nxt      = placed_r | cand_bit;
            lvl_nxt         = lvl_r + LW'(1);
            cand_nxt        = '0;
          end else begin
            cand_nxt = cand_r + LW'(1);
          end
        end
      end
      topo_pkg::ST_BACK: begin
        if (lvl_r == '0) begin
          give_fin = 1'b1;
        end else begin
          stack_req.rd_en = 1'b1;
          stack_req.addr  = IW'(lvl_r - LW'(1));
          lvl_nxt         = lvl_r - LW'(1);
        end
      end
      topo_pkg::ST_POP: begin
        // unplace the popped item and resume after it
        placed_nxt = placed_r & ~(CAP'(1) << pop_idx);
        cand_nxt   = LW'(pop_idx) + LW'(1);
      end
      topo_pkg::ST_EMIT_RD: begin
        stack_req.rd_en = 1'b1;
        stack_req.addr  = IW'(k_r);
      end
      topo_pkg::ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = stack_rdata;
        out_last_nxt  = (k_r == n_m1);
        out_fin_nxt   = 1'b0;
        out_none_nxt  = 1'b0;
      end
      topo_pkg::ST_EMIT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + LW'(1);
        end
      end
      topo_pkg::ST_FIN_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (give_fin) begin
      done_nxt      = 1'b1;
      lvl_nxt       = '0;
      out_valid_nxt = 1'b1;
      out_item_nxt  = 4'd0;
      out_last_nxt  = 1'b0;
      out_fin_nxt   = 1'b1;
      out_none_nxt  = !any_r;
    end

    // constraints survive a count change, the enumeration does not
    if (cfg_wr_en) begin
      n_nxt       = n_cfg;
      placed_nxt  = '0;
      lvl_nxt     = '0;
      started_nxt = 1'b0;
      done_nxt    = 1'b0;
      any_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= topo_pkg::ST_IDLE;
      n_r         <= LW'(CAP);
      placed_r    <= '0;
      lvl_r       <= '0;
      cand_r      <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      prog_r      <= 1'b0;
      started_r   <= 1'b0;
      done_r      <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      placed_r    <= placed_nxt;
      lvl_r       <= lvl_nxt;
      cand_r      <= cand_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      prog_r      <= prog_nxt;
      started_r   <= started_nxt;
      done_r      <= done_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
    out_fin_r  <= out_fin_nxt;
    out_none_r <= out_none_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_item_index       = out_item_r;
  assign out_last_of_ordering = out_last_r;
  assign out_finished         = out_fin_r;
  assign out_none_found       = out_none_r;

endmodule

// ===== rtl/core/topo_checker.sv =====
// ----------------------------------------------------------------------------
// topo_checker
// port-level checks of the topological order enumerator
// ----------------------------------------------------------------------------
module topo_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_item_index,
  input logic       out_last_of_ordering,
  input logic       out_finished,
  input logic       out_none_found
);

  // a finished item carries no position
  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_item_index == 4'd0 && !out_last_of_ordering))
    else $error("finished item carries an index or last flag");

  // none_found only rides on a finished item
  a_none_with_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_finished) |-> !out_none_found)
    else $error("none_found without finished");

  // no new item is taken while a result is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item_index)
                                   && $stable(out_finished)))
    else $error("stalled result changed");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind topological_order_enumerator topo_checker u_topo_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_item_index       (out_item_index),
  .out_last_of_ordering (out_last_of_ordering),
  .out_finished         (out_finished),
  .out_none_found       (out_none_found)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the topological order enumerator: a transaction-level
// predictor works out every ordering the block should give, results are
// checked in order against it under random idling, stalls and back-pressure
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS = 16;
  localparam int ITEM_CAP = (MAX_ITEMS < 16) ? MAX_ITEMS : 16;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [3:0] idx;
    logic       last;
    logic       fin;
    logic       none;
  } position_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_item_count = 5'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_func = topo_pkg::FUNC_CLEAR;
  logic [3:0] in_earlier_index = 4'd0;
  logic [3:0] in_later_index = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_item_index;
  logic       out_last_of_ordering;
  logic       out_finished;
  logic       out_none_found;

  topological_order_enumerator #(
    .MAX_ITEMS(MAX_ITEMS)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_item_count      (cfg_item_count),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_earlier_index    (in_earlier_index),
    .in_later_index      (in_later_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_item_index      (out_item_index),
    .out_last_of_ordering(out_last_of_ordering),
    .out_finished        (out_finished),
    .out_none_found      (out_none_found)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [15:0] pred_mask [MAX_ITEMS];
  logic [3:0]  order_stack [16];
  logic [15:0] placed_set;
  int unsigned stack_depth;
  bit          enum_started;
  bit          enum_done;
  bit          found_any;
  logic [4:0]  count_reg;

  position_t   awaited_positions[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  function automatic void restart_enum();
    placed_set   = '0;
    stack_depth  = 0;
    enum_started = 1'b0;
    enum_done    = 1'b0;
    found_any    = 1'b0;
  endfunction

  function automatic void reset_model();
    count_reg = 5'd16;
    for (int k = 0; k < MAX_ITEMS; k++) pred_mask[k] = '0;
    for (int k = 0; k < 16; k++) order_stack[k] = '0;
    restart_enum();
  endfunction

  function automatic int unsigned active_items();
    int unsigned n;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > ITEM_CAP) n = ITEM_CAP;
    return n;
  endfunction

  function automatic bit ready_to_place(int unsigned c, logic [15:0] done_set);
    if (done_set[c]) return 1'b0;
    return (done_set & pred_mask[c]) == pred_mask[c];
  endfunction

  // quick cycle check: can every item be placed at all
  function automatic bit orderable(int unsigned n);
    logic [15:0] done_set;
    int unsigned cnt;
    int unsigned c;
    bit moved;
    done_set = '0;
    cnt = 0;
    moved = 1'b1;
    while (moved && cnt < n) begin
      moved = 1'b0;
      for (c = 0; c < n; c++) begin
        if (ready_to_place(c, done_set)) begin
          done_set[c] = 1'b1;
          cnt++;
          moved = 1'b1;
        end
      end
    end
    return cnt == n;
  endfunction

  // depth-first search from a given level and first candidate
  function automatic bit dfs_resume(int unsigned lvl, int unsigned from, int unsigned n);
    int unsigned c;
    forever begin
      if (lvl >= n) begin
        stack_depth = n;
        return 1'b1;
      end
      c = from;
      while (c < n && !ready_to_place(c, placed_set)) c++;
      if (c < n) begin
        order_stack[lvl] = 4'(c);
        placed_set[c] = 1'b1;
        lvl++;
        from = 0;
      end else begin
        if (lvl == 0) begin
          stack_depth = 0;
          return 1'b0;
        end
        lvl--;
        c = order_stack[lvl] % MAX_ITEMS;
        placed_set[c] = 1'b0;
        from = c + 1;
      end
    end
  endfunction

  function automatic void predict_item(logic [1:0] f, logic [3:0] e, logic [3:0] l);
    int unsigned n;
    int unsigned lvl;
    int unsigned c;
    bit got;
    position_t r;
    n = active_items();
    got = 1'b0;
    case (f)
      topo_pkg::FUNC_CLEAR: begin
        for (int k = 0; k < MAX_ITEMS; k++) pred_mask[k] = '0;
        restart_enum();
      end
      topo_pkg::FUNC_ADD: begin
        if (e < MAX_ITEMS && l < MAX_ITEMS) pred_mask[l][e] = 1'b1;
        restart_enum();
      end
      topo_pkg::FUNC_NEXT: begin
        if (enum_done) begin
          got = 1'b0;
        end else if (!enum_started) begin
          enum_started = 1'b1;
          placed_set = '0;
          stack_depth = 0;
          got = orderable(n) ? dfs_resume(0, 0, n) : 1'b0;
        end else begin
          lvl = stack_depth;
          if (lvl == 0 || lvl > n) begin
            got = 1'b0;
          end else begin
            lvl--;
            c = order_stack[lvl] % MAX_ITEMS;
            placed_set[c] = 1'b0;
            got = dfs_resume(lvl, c + 1, n);
          end
        end
        if (!got) begin
          enum_done = 1'b1;
          stack_depth = 0;
          r.idx  = 4'd0;
          r.last = 1'b0;
          r.fin  = 1'b1;
          r.none = !found_any;
          awaited_positions = {awaited_positions, r};
        end else begin
          found_any = 1'b1;
          for (int unsigned k = 0; k < n; k++) begin
            r.idx  = order_stack[k];
            r.last = (k + 1 == n);
            r.fin  = 1'b0;
            r.none = 1'b0;
            awaited_positions = {awaited_positions, r};
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    position_t got;
    position_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.idx  = out_item_index;
      got.last = out_last_of_ordering;
      got.fin  = out_finished;
      got.none = out_none_found;
      if (awaited_positions.size() == 0) begin
        report_mismatch($sformatf("unexpected item idx=%0d last=%0b fin=%0b none=%0b",
                                  got.idx, got.last, got.fin, got.none));
      end else begin
        want = awaited_positions.pop_front();
        if (got.idx !== want.idx || got.last !== want.last ||
            got.fin !== want.fin || got.none !== want.none)
          report_mismatch($sformatf("got idx=%0d last=%0b fin=%0b none=%0b, want %0d %0b %0b %0b",
                                    got.idx, got.last, got.fin, got.none,
                                    want.idx, want.last, want.fin, want.none));
      end
    end
  end

  // receiver stalls, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] f, input logic [3:0] e, input logic [3:0] l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= f;
    in_earlier_index <= e;
    in_later_index   <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_item(f, e, l);
  endtask

  task automatic request_orderings(input int cnt);
    repeat (cnt) send_item(topo_pkg::FUNC_NEXT, 4'($urandom_range(15)),
                           4'($urandom_range(15)));
  endtask

  // wait for every expected position, then let clear/add work finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_item_count(input logic [4:0] v);
    settle();
    cfg_wr_en      <= 1'b1;
    cfg_item_count <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_reg = v;
    restart_enum();
  endtask

  // three items: every ordering, then finished, then finished again
  task automatic test_full_enumeration();
    write_item_count(5'd3);
    request_orderings(8);
  endtask

  task automatic test_count_extremes();
    write_item_count(5'd0);
    request_orderings(3);
    write_item_count(5'd31);
    request_orderings(1);
    write_item_count(5'd17);
    write_item_count(5'd16);
    request_orderings(1);
  endtask

  task automatic test_constraints();
    write_item_count(5'd4);
    send_item(topo_pkg::FUNC_ADD, 4'd3, 4'd0);
    send_item(topo_pkg::FUNC_ADD, 4'd2, 4'd1);
    send_item(FUNC_UNUSED, 4'd15, 4'd15);
    request_orderings(2);
    // rewriting the count restarts but keeps the masks
    write_item_count(5'd4);
    request_orderings(1);
    // self constraint
    send_item(topo_pkg::FUNC_ADD, 4'd1, 4'd1);
    request_orderings(1);
    // two-item cycle
    send_item(topo_pkg::FUNC_CLEAR, 4'd15, 4'd0);
    send_item(topo_pkg::FUNC_ADD, 4'd0, 4'd2);
    send_item(topo_pkg::FUNC_ADD, 4'd2, 4'd0);
    request_orderings(1);
    // predecessor outside the active range
    send_item(topo_pkg::FUNC_CLEAR, 4'd0, 4'd15);
    send_item(topo_pkg::FUNC_ADD, 4'd15, 4'd1);
    request_orderings(1);
  endtask

  // long receiver hold-off while next requests keep coming
  task automatic test_backpressure();
    write_item_count(5'd4);
    send_item(topo_pkg::FUNC_CLEAR, 4'd0, 4'd0);
    hold_left = 300;
    request_orderings(6);
  endtask

  function automatic logic [4:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 5'($urandom_range(2, 5));
    if (roll < 88) return 5'($urandom_range(6, 8));
    case ($urandom_range(4))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd31;
      default: return 5'($urandom_range(9, 30));
    endcase
  endfunction

  // restart, a few constraints, then a run of next requests
  task automatic test_random_sessions(input int sidle, input int rstall, input int budget);
    int sent;
    int n;
    int nadd;
    int roll;
    logic [3:0] e;
    logic [3:0] l;
    sent = 0;
    settle();
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    while (sent < budget) begin
      if ($urandom_range(2) == 0) write_item_count(pick_count());
      n = active_items();
      send_item(topo_pkg::FUNC_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)));
      sent++;
      nadd = $urandom_range(0, 5);
      repeat (nadd) begin
        roll = $urandom_range(99);
        if (roll < 75 && n >= 2) begin
          e = 4'($urandom_range(0, n - 2));
          l = 4'($urandom_range(e + 1, n - 1));
          send_item(topo_pkg::FUNC_ADD, e, l);
          sent++;
        end else if (roll < 92) begin
          send_item(topo_pkg::FUNC_ADD, 4'($urandom_range(15)), 4'($urandom_range(15)));
          sent++;
        end else begin
          send_item(FUNC_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)));
        end
      end
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(9) == 0)
          send_item(FUNC_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)));
        request_orderings(1);
        sent++;
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_enumeration();
    test_count_extremes();
    test_constraints();
    test_backpressure();
    test_random_sessions(7, 45, 50);
    test_random_sessions(45, 7, 50);
    test_random_sessions(0, 0, 50);

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
